FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under asynchronous active-low reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication under asynchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/tpns_pkg.sv
// Types, constants and helpers of the two-class priority scheduler
package tpns_pkg;

	localparam int QUEUE_DEPTH_DEF      = 16;
	localparam int TICKS_PER_SECOND_DEF = 10;
	localparam int QUEUE_DEPTH_MAX      = 1024;
	localparam int SVC_W                = 8;
	localparam int STAMP_W              = 32;
	localparam int CNT_W                = $clog2(QUEUE_DEPTH_MAX + 1);

	// Class codes
	localparam logic CLASS_HIGH = 1'b0;
	localparam logic CLASS_LOW  = 1'b1;

	typedef struct packed {
		logic             arrival_valid;
		logic             arrival_priority;
		logic [SVC_W-1:0] arrival_service_seconds;
	} in_t;

	typedef struct packed {
		logic        job_done;
		logic        done_priority;
		logic [31:0] done_wait_ticks;
		logic [31:0] wait_total_high;
		logic [31:0] wait_total_low;
		logic [31:0] done_count_high;
		logic [31:0] done_count_low;
		logic [31:0] length_total;
		logic [31:0] arrival_count;
		logic [31:0] service_total_seconds;
		logic [31:0] elapsed_ticks;
		logic        dropped;
	} out_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [SVC_W-1:0]   service;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		logic     pop;
		q_entry_t entry;
	} q_ctl_t;

	// Queue view after this tick's arrival is taken in
	typedef struct packed {
		logic             full;
		logic             nonempty;
		logic [CNT_W-1:0] count;
		q_entry_t         head;
	} q_stat_t;

	typedef struct packed {
		logic pop_high;
		logic pop_low;
	} srv_pop_t;

	typedef struct packed {
		logic        job_done;
		logic        done_priority;
		logic [31:0] done_wait_ticks;
	} srv_res_t;

	typedef struct packed {
		logic [31:0] wait_total_high;
		logic [31:0] wait_total_low;
		logic [31:0] done_count_high;
		logic [31:0] done_count_low;
		logic [31:0] length_total;
		logic [31:0] arrival_count;
		logic [31:0] service_total_seconds;
		logic [31:0] elapsed_ticks;
	} stats_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

FILE: rtl/core/tpns_queue.sv
// Per-class job FIFO with a registered head entry and same-tick bypass
module tpns_queue #(
	parameter int DEPTH = tpns_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpns_pkg::q_ctl_t  ctl,
	output tpns_pkg::q_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CQ_W  = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	tpns_pkg::q_entry_t mem [DEPTH];
	tpns_pkg::q_entry_t head_q;
	logic [PTR_W-1:0]   head_ptr_q;
	logic [CQ_W-1:0]    count_q;

	logic [SUM_W-1:0]   tail_sum;
	logic [PTR_W-1:0]   tail;
	logic [PTR_W-1:0]   head_inc;
	logic [PTR_W-1:0]   head_d;
	logic [CQ_W-1:0]    count_d;
	logic               empty_q;

	// Locate the tail and the next head
	always_comb begin
		tail_sum = SUM_W'(head_ptr_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(DEPTH)) begin
			tail = PTR_W'(tail_sum - SUM_W'(DEPTH));
		end else begin
			tail = PTR_W'(tail_sum);
		end
		head_inc = (head_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : head_ptr_q + 1'b1;
		head_d   = ctl.pop ? head_inc : head_ptr_q;
		count_d  = count_q + CQ_W'(ctl.push) - CQ_W'(ctl.pop);
		empty_q  = (count_q == '0);
	end

	// Report the view after the arrival; an empty queue shows the arriving job
	always_comb begin
		stat.full     = (count_q == CQ_W'(DEPTH));
		stat.nonempty = !empty_q || ctl.push;
		stat.count    = tpns_pkg::CNT_W'(count_q + CQ_W'(ctl.push));
		stat.head     = empty_q ? ctl.entry : head_q;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			count_q    <= '0;
		end else begin
			head_ptr_q <= head_d;
			count_q    <= count_d;
		end
	end

	// Write the arriving job at the tail
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail] <= ctl.entry;
		end
	end

	// Register the next head entry, forwarding a same-tick write
	always_ff @(posedge clk) begin
		if (ctl.push && (tail == head_d)) begin
			head_q <= ctl.entry;
		end else begin
			head_q <= mem[head_d];
		end
	end

endmodule

FILE: rtl/core/tpns_server.sv
// Nonpreemptive server: class selection, service countdown and wait capture
module tpns_server #(
	parameter int TICKS_PER_SECOND = tpns_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic [31:0]        now,
	input  tpns_pkg::q_stat_t  hi,
	input  tpns_pkg::q_stat_t  lo,
	output tpns_pkg::srv_pop_t pop,
	output tpns_pkg::srv_res_t res
);

	localparam int REM_W = $clog2((2**tpns_pkg::SVC_W - 1) * TICKS_PER_SECOND + 1);

	logic [REM_W-1:0]   rem_q;
	logic [31:0]        wait_q;
	logic               head_started_q;
	logic               serving_low_q;

	logic               sel_high;
	logic               sel_low;
	logic               serving;
	tpns_pkg::q_entry_t head;
	logic [REM_W-1:0]   load;
	logic [REM_W-1:0]   rem_cur;
	logic [REM_W-1:0]   rem_new;
	logic [31:0]        wait_cur;
	logic               done;

	// Pick the class and count down the head job
	always_comb begin
		sel_high = hi.nonempty && !serving_low_q;
		sel_low  = !sel_high && lo.nonempty;
		serving  = tick && (sel_high || sel_low);
		head     = sel_high ? hi.head : lo.head;
		load     = REM_W'(head.service) * REM_W'(TICKS_PER_SECOND);
		if (head_started_q) begin
			rem_cur  = rem_q;
			wait_cur = wait_q;
		end else begin
			rem_cur  = (load == '0) ? REM_W'(1) : load;
			wait_cur = now - head.stamp;
		end
		rem_new = rem_cur - 1'b1;
		done    = serving && (rem_new == '0);
	end

	// Drive pops and the completion record
	always_comb begin
		pop.pop_high        = done && sel_high;
		pop.pop_low         = done && sel_low;
		res.job_done        = done;
		res.done_priority   = done ? (sel_low ? tpns_pkg::CLASS_LOW : tpns_pkg::CLASS_HIGH)
		                           : tpns_pkg::CLASS_HIGH;
		res.done_wait_ticks = done ? wait_cur : '0;
	end

	// Hold service state across ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q          <= '0;
			wait_q         <= '0;
			head_started_q <= 1'b0;
			serving_low_q  <= 1'b0;
		end else if (serving) begin
			rem_q <= rem_new;
			if (done) begin
				head_started_q <= 1'b0;
				serving_low_q  <= 1'b0;
			end else begin
				head_started_q <= 1'b1;
				wait_q         <= wait_cur;
				if (sel_low) begin
					serving_low_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/tpns_stats.sv
// Saturating statistics counters and the tick counter
module tpns_stats (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      accepted,
	input  logic [tpns_pkg::SVC_W-1:0] service,
	input  logic [tpns_pkg::CNT_W:0]   len_sum,
	input  tpns_pkg::srv_res_t        res,
	output tpns_pkg::stats_t          stats
);

	tpns_pkg::stats_t stats_q;

	assign stats = stats_q;

	// Accumulate totals once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
		end else if (tick) begin
			stats_q.elapsed_ticks <= stats_q.elapsed_ticks + 32'd1;
			if (accepted) begin
				stats_q.arrival_count <= tpns_pkg::sat_add(stats_q.arrival_count, 32'd1);
				stats_q.service_total_seconds <=
					tpns_pkg::sat_add(stats_q.service_total_seconds, 32'(service));
				stats_q.length_total <= tpns_pkg::sat_add(stats_q.length_total, 32'(len_sum));
			end
			if (res.job_done) begin
				if (res.done_priority == tpns_pkg::CLASS_LOW) begin
					stats_q.wait_total_low <=
						tpns_pkg::sat_add(stats_q.wait_total_low, res.done_wait_ticks);
					stats_q.done_count_low <=
						tpns_pkg::sat_add(stats_q.done_count_low, 32'd1);
				end else begin
					stats_q.wait_total_high <=
						tpns_pkg::sat_add(stats_q.wait_total_high, res.done_wait_ticks);
					stats_q.done_count_high <=
						tpns_pkg::sat_add(stats_q.done_count_high, 32'd1);
				end
			end
		end
	end

endmodule

FILE: rtl/core/two_priority_nonpreemptive_scheduler_core.sv
// The transfer of an accepted tick is registered into valid_s1 and item_s1, then the result fields
// and the counters are registered; the result is on the ports for one cycle.
// Throughput: one tick per cycle; busy never rises, each tick is one register-to-register pass
// over the queue heads, the service countdown and the counters.
// Reset: asynchronous, active low; clears queue pointers, service state and all totals.
// Queue storage needs no clearing; the result strobe cannot be stalled by the receiver.
`include "assert_macros.svh"
module two_priority_nonpreemptive_scheduler_core #(
	parameter int QUEUE_DEPTH      = tpns_pkg::QUEUE_DEPTH_DEF,
	parameter int TICKS_PER_SECOND = tpns_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tpns_pkg::in_t item,
	output logic          result_valid,
	output tpns_pkg::out_t result
);

	logic               valid_s1;
	tpns_pkg::in_t      item_s1;

	tpns_pkg::q_ctl_t   hi_ctl;
	tpns_pkg::q_ctl_t   lo_ctl;
	tpns_pkg::q_stat_t  hi_stat;
	tpns_pkg::q_stat_t  lo_stat;
	tpns_pkg::srv_pop_t pop;
	tpns_pkg::srv_res_t res;
	tpns_pkg::stats_t   stats;

	logic               arrive;
	logic               to_low;
	logic               drop;
	logic               accepted;
	logic [tpns_pkg::CNT_W:0] len_sum;

	logic               strobe_q;
	logic               job_done_q;
	logic               done_prio_q;
	logic [31:0]        done_wait_q;
	logic               dropped_q;

	assign busy = 1'b0;

	// Capture the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Route the arrival to its class, drop it when that queue is full
	always_comb begin
		arrive   = valid_s1 && item_s1.arrival_valid;
		to_low   = (item_s1.arrival_priority == tpns_pkg::CLASS_LOW);
		drop     = arrive && (to_low ? lo_stat.full : hi_stat.full);
		accepted = arrive && !drop;

		hi_ctl.push          = accepted && !to_low;
		hi_ctl.pop           = pop.pop_high;
		hi_ctl.entry.stamp   = stats.elapsed_ticks;
		hi_ctl.entry.service = item_s1.arrival_service_seconds;
		lo_ctl.push          = accepted && to_low;
		lo_ctl.pop           = pop.pop_low;
		lo_ctl.entry.stamp   = stats.elapsed_ticks;
		lo_ctl.entry.service = item_s1.arrival_service_seconds;

		len_sum = (tpns_pkg::CNT_W + 1)'(hi_stat.count) + (tpns_pkg::CNT_W + 1)'(lo_stat.count);
	end

	tpns_queue #(.DEPTH(QUEUE_DEPTH)) u_high_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hi_ctl),
		.stat  (hi_stat)
	);

	tpns_queue #(.DEPTH(QUEUE_DEPTH)) u_low_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lo_ctl),
		.stat  (lo_stat)
	);

	tpns_server #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_server (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (valid_s1),
		.now   (stats.elapsed_ticks),
		.hi    (hi_stat),
		.lo    (lo_stat),
		.pop   (pop),
		.res   (res)
	);

	tpns_stats u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (valid_s1),
		.accepted(accepted),
		.service (item_s1.arrival_service_seconds),
		.len_sum (len_sum),
		.res     (res),
		.stats   (stats)
	);

	// Register the per-tick result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q   <= 1'b0;
			job_done_q <= 1'b0;
		end else begin
			strobe_q   <= valid_s1;
			job_done_q <= valid_s1 && res.job_done;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			done_prio_q <= res.done_priority;
			done_wait_q <= res.done_wait_ticks;
			dropped_q   <= drop;
		end
	end

	// Assemble the result transfer
	always_comb begin
		result_valid                 = strobe_q;
		result.job_done              = job_done_q;
		result.done_priority         = done_prio_q;
		result.done_wait_ticks       = done_wait_q;
		result.wait_total_high       = stats.wait_total_high;
		result.wait_total_low        = stats.wait_total_low;
		result.done_count_high       = stats.done_count_high;
		result.done_count_low        = stats.done_count_low;
		result.length_total          = stats.length_total;
		result.arrival_count         = stats.arrival_count;
		result.service_total_seconds = stats.service_total_seconds;
		result.elapsed_ticks         = stats.elapsed_ticks;
		result.dropped               = dropped_q;
	end

	`ASSERT_IMPLY(a_one_pop, clk, arst_n, pop.pop_high, !pop.pop_low)
	`ASSERT_IMPLY(a_done_strobed, clk, arst_n, !result_valid, !result.job_done)
	`ASSERT_IMPLY(a_drop_no_count, clk, arst_n, result_valid && result.dropped, $stable(result.arrival_count))
	`ASSERT_NEXT(a_tick_strobe, clk, arst_n, valid_s1, result_valid)

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the two-class non-preemptive priority scheduler core
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH        = tpns_pkg::QUEUE_DEPTH_DEF;
	localparam int TPS          = tpns_pkg::TICKS_PER_SECOND_DEF;
	localparam int RANDOM_TICKS = 1300;
	localparam int QUIET_LIMIT  = 1000;
	localparam int SETTLE       = 8;

	// Scheduler model and the queue of per-tick reports it predicts
	class tick_scoreboard;
		logic [31:0]      stamp_q [2][DEPTH];
		logic [7:0]       svc_q [2][DEPTH];
		int unsigned      head [2];
		int unsigned      count [2];
		int unsigned      remaining;
		bit               low_started;
		bit               head_started;
		logic [31:0]      wait_tot [2];
		logic [31:0]      done_cnt [2];
		logic [31:0]      len_tot;
		logic [31:0]      arr_cnt;
		logic [31:0]      svc_tot;
		logic [31:0]      ticks;
		tpns_pkg::out_t   expected_reports [$];
		int               errors;

		function new();
			head = '{0, 0};
			count = '{0, 0};
			remaining = 0;
			low_started = 0;
			head_started = 0;
			wait_tot = '{0, 0};
			done_cnt = '{0, 0};
			len_tot = 0;
			arr_cnt = 0;
			svc_tot = 0;
			ticks = 0;
			errors = 0;
		endfunction

		function logic [31:0] clip_add(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function int unsigned queued_jobs();
			return count[tpns_pkg::CLASS_HIGH] + count[tpns_pkg::CLASS_LOW];
		endfunction

		function int unsigned pending();
			return expected_reports.size();
		endfunction

		// Advance the model by one accepted tick and queue its report
		function void note_tick(tpns_pkg::in_t t);
			tpns_pkg::out_t e;
			logic [31:0]    now;
			logic           cls;
			logic           sc;
			bit             serve;
			int unsigned    slot;
			int unsigned    load;
			now = ticks;
			e = '0;
			// Enqueue the arrival, or drop it on a full queue
			if (t.arrival_valid) begin
				cls = t.arrival_priority;
				if (count[cls] >= DEPTH) begin
					e.dropped = 1'b1;
				end else begin
					slot = (head[cls] + count[cls]) % DEPTH;
					stamp_q[cls][slot] = now;
					svc_q[cls][slot] = t.arrival_service_seconds;
					count[cls]++;
					arr_cnt = clip_add(arr_cnt, 1);
					svc_tot = clip_add(svc_tot, t.arrival_service_seconds);
					len_tot = clip_add(len_tot,
						count[tpns_pkg::CLASS_HIGH] + count[tpns_pkg::CLASS_LOW]);
				end
			end
			// Pick the class to serve; a started low job holds the server
			serve = 1'b1;
			sc = tpns_pkg::CLASS_HIGH;
			if (count[tpns_pkg::CLASS_HIGH] > 0 && !low_started) begin
				sc = tpns_pkg::CLASS_HIGH;
			end else if (count[tpns_pkg::CLASS_LOW] > 0) begin
				sc = tpns_pkg::CLASS_LOW;
				low_started = 1'b1;
			end else begin
				serve = 1'b0;
			end
			// Work one tick on the head job
			if (serve) begin
				slot = head[sc];
				if (!head_started) begin
					load = svc_q[sc][slot] * TPS;
					remaining = (load != 0) ? load : 1;
					stamp_q[sc][slot] = now - stamp_q[sc][slot];
					head_started = 1'b1;
				end
				remaining--;
				if (remaining == 0) begin
					e.job_done = 1'b1;
					e.done_priority = sc;
					e.done_wait_ticks = stamp_q[sc][slot];
					wait_tot[sc] = clip_add(wait_tot[sc], stamp_q[sc][slot]);
					done_cnt[sc] = clip_add(done_cnt[sc], 1);
					head[sc] = (slot + 1) % DEPTH;
					count[sc]--;
					head_started = 1'b0;
					low_started = 1'b0;
				end
			end
			ticks = now + 1;
			e.wait_total_high = wait_tot[tpns_pkg::CLASS_HIGH];
			e.wait_total_low = wait_tot[tpns_pkg::CLASS_LOW];
			e.done_count_high = done_cnt[tpns_pkg::CLASS_HIGH];
			e.done_count_low = done_cnt[tpns_pkg::CLASS_LOW];
			e.length_total = len_tot;
			e.arrival_count = arr_cnt;
			e.service_total_seconds = svc_tot;
			e.elapsed_ticks = ticks;
			expected_reports.push_back(e);
		endfunction

		function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, fname, want, got);
			end
		endfunction

		// Compare one report with the oldest prediction
		function void check_result(tpns_pkg::out_t got);
			tpns_pkg::out_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t: report with no tick waiting, expected none, actual elapsed %0d",
					$time, got.elapsed_ticks);
				return;
			end
			want = expected_reports.pop_front();
			compare_field("job_done", want.job_done, got.job_done);
			compare_field("done_priority", want.done_priority, got.done_priority);
			compare_field("done_wait_ticks", want.done_wait_ticks, got.done_wait_ticks);
			compare_field("wait_total_high", want.wait_total_high, got.wait_total_high);
			compare_field("wait_total_low", want.wait_total_low, got.wait_total_low);
			compare_field("done_count_high", want.done_count_high, got.done_count_high);
			compare_field("done_count_low", want.done_count_low, got.done_count_low);
			compare_field("length_total", want.length_total, got.length_total);
			compare_field("arrival_count", want.arrival_count, got.arrival_count);
			compare_field("service_total_seconds", want.service_total_seconds,
				got.service_total_seconds);
			compare_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
			compare_field("dropped", want.dropped, got.dropped);
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	tpns_pkg::in_t  item;
	logic           result_valid;
	tpns_pkg::out_t result;

	tick_scoreboard board;
	int             quiet_cycles;

	two_priority_nonpreemptive_scheduler_core #(
		.QUEUE_DEPTH(DEPTH),
		.TICKS_PER_SECOND(TPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check reports and watch for a stalled run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (result_valid === 1'b1)
				board.check_result(result);
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL two_priority_nonpreemptive_scheduler_core");
				$finish;
			end
		end
	end

	function automatic tpns_pkg::in_t make_tick(logic valid, logic prio, logic [7:0] svc);
		tpns_pkg::in_t t;
		t.arrival_valid = valid;
		t.arrival_priority = prio;
		t.arrival_service_seconds = svc;
		return t;
	endfunction

	// Draw one tick; arrivals mostly carry short service times
	function automatic tpns_pkg::in_t random_tick(int unsigned rate_pct, int unsigned low_pct);
		tpns_pkg::in_t t;
		t.arrival_valid = ($urandom_range(0, 99) < rate_pct);
		t.arrival_priority = ($urandom_range(0, 99) < low_pct) ? tpns_pkg::CLASS_LOW
		                                                       : tpns_pkg::CLASS_HIGH;
		if (!t.arrival_valid)
			t.arrival_service_seconds = 8'($urandom);
		else if ($urandom_range(0, 499) == 0)
			t.arrival_service_seconds = 8'($urandom_range(0, 255));
		else if ($urandom_range(0, 3) == 0)
			t.arrival_service_seconds = 8'd0;
		else
			t.arrival_service_seconds = 8'($urandom_range(1, 3));
		return t;
	endfunction

	// Hold the tick on the bus until it is taken; returns at the next falling edge
	task automatic send_tick(input tpns_pkg::in_t t);
		start <= 1'b1;
		item <= t;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_tick(t);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		while ($urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned burst_left;
		int unsigned rate_pct;
		int unsigned low_pct;
		int unsigned pick;
		board = new();
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: idle server, zero service, a started low job holding off a high
		// arrival, a masked arrival with its other fields high, a long job, then a full
		// high queue
		send_tick(make_tick(1'b0, tpns_pkg::CLASS_HIGH, 8'd0));
		send_tick(make_tick(1'b1, tpns_pkg::CLASS_HIGH, 8'd0));
		send_tick(make_tick(1'b1, tpns_pkg::CLASS_LOW, 8'd0));
		send_tick(make_tick(1'b1, tpns_pkg::CLASS_LOW, 8'd1));
		send_tick(make_tick(1'b1, tpns_pkg::CLASS_HIGH, 8'd0));
		send_tick(make_tick(1'b0, tpns_pkg::CLASS_LOW, 8'd255));
		send_tick(make_tick(1'b1, tpns_pkg::CLASS_HIGH, 8'd40));
		for (int i = 0; i < 18; i++)
			send_tick(make_tick(1'b1, tpns_pkg::CLASS_HIGH, 8'(i % 2)));

		// Run empty ticks until the long job and the backlog are gone
		while (board.queued_jobs() != 0) begin
			idle_gap();
			send_tick(random_tick(0, 50));
		end

		// Random bursts of varying load and class mix
		burst_left = 0;
		rate_pct = 0;
		low_pct = 0;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(10, 60);
				pick = $urandom_range(0, 99);
				if (pick < 40)
					rate_pct = $urandom_range(1, 8);
				else if (pick < 80)
					rate_pct = $urandom_range(10, 40);
				else
					rate_pct = 100;
				low_pct = $urandom_range(0, 100);
			end
			burst_left--;
			if (n == RANDOM_TICKS / 2)
				wait_for_results();
			if (n < 700 || n >= 1000)
				idle_gap();
			send_tick(random_tick(rate_pct, low_pct));
		end

		// Drain outstanding reports, then let the pipeline settle
		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS two_priority_nonpreemptive_scheduler_core");
		else
			$display("FAIL two_priority_nonpreemptive_scheduler_core");
		$finish;
	end

endmodule
